>>> design/dsq_pkg.sv
// Package for the deadline-sorted queue: request and status codes,
// entry layout and the packed request/result transfer types.
// No dependencies.
`timescale 1ns / 1ps

package dsq_pkg;

    // Request codes
    typedef enum logic [1:0] {
        REQ_INSERT       = 2'd0,
        REQ_REMOVE_KEY   = 2'd1,
        REQ_REMOVE_FIRST = 2'd2,
        REQ_TICK         = 2'd3
    } req_t;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // One stored entry
    typedef struct packed {
        logic [7:0] key;
        logic [7:0] deadline;
        logic [7:0] points;
    } entry_t;

    // Request transfer
    typedef struct packed {
        req_t       req_type;
        logic [7:0] key;
        logic [7:0] deadline;
        logic [7:0] points;
    } request_t;

    // Result transfer
    typedef struct packed {
        status_t    status;
        logic       expired;
        logic [3:0] count;
        logic       head_valid;
        logic [7:0] head_key;
        logic [7:0] head_deadline;
        logic [7:0] head_points;
    } result_t;

endpackage

>>> design/dsq_ram.sv
// Entry store of the deadline-sorted queue: one write port, one read
// port, read data registered. Depends on dsq_pkg.
`timescale 1ns / 1ps

module dsq_ram #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  dsq_pkg::entry_t     wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output dsq_pkg::entry_t     rd_data
);

    dsq_pkg::entry_t mem [DEPTH];
    dsq_pkg::entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/deadline_sorted_queue.sv
// Deadline-sorted queue: sequencer that walks the entry store for each
// request. Depends on dsq_pkg and dsq_ram.
//
// Flow: a walking request passes S_RUN, S_FINISH, S_HEAD and S_RESULT in turn;
// insert or tick on an empty queue starts at S_FINISH, and a full insert or a
// remove on an empty queue starts at S_HEAD.
// Throughput: one request at a time; busy falls the cycle after the result.
// The walk handles one entry per cycle over the store's single read and write
// port.
// Reset: occupancy and expired flag clear at once; entries stay undefined.
// Results are shown on done for one cycle and cannot be stalled.
`timescale 1ns / 1ps

module deadline_sorted_queue #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dsq_pkg::request_t  request,
    output logic               done,
    output dsq_pkg::result_t   result
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RUN    = 5'b00010,
        S_FINISH = 5'b00100,
        S_HEAD   = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    dsq_pkg::req_t      op_reg, op_next;
    dsq_pkg::status_t   status_reg, status_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               flag_reg, flag_next;
    logic               expired_reg, expired_next;
    logic [7:0]         key_reg, key_next;
    logic [7:0]         dl_reg, dl_next;
    logic [7:0]         pts_reg, pts_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    dsq_pkg::entry_t    wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    dsq_pkg::entry_t    rd_data;
    dsq_pkg::entry_t    new_entry;
    dsq_pkg::entry_t    tick_entry;
    logic               match;

    dsq_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Entry built from the request, the ticked copy of the read entry and the match flag
    always_comb
    begin
        new_entry.key      = key_reg;
        new_entry.deadline = dl_reg;
        new_entry.points   = pts_reg;
        tick_entry         = rd_data;
        if (rd_data.deadline != 8'd0)
        begin
            tick_entry.deadline = rd_data.deadline - 8'd1;
        end
        if (op_reg == dsq_pkg::REQ_REMOVE_FIRST)
        begin
            match = (pend_idx_reg == '0);
        end
        else
        begin
            match = (rd_data.key == key_reg);
        end
    end

    // Sequencer: while walking, issue one read per cycle and act on the entry read last cycle
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        occ_next        = occ_reg;
        left_next       = left_reg;
        ptr_next        = ptr_reg;
        pend_idx_next   = pend_idx_reg;
        pend_valid_next = pend_valid_reg;
        flag_next       = flag_reg;
        expired_next    = expired_reg;
        key_next        = key_reg;
        dl_next         = dl_reg;
        pts_next        = pts_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = new_entry;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next         = request.req_type;
                    key_next        = request.key;
                    dl_next         = request.deadline;
                    pts_next        = request.points;
                    status_next     = dsq_pkg::ST_OK;
                    flag_next       = 1'b0;
                    pend_valid_next = 1'b0;
                    left_next       = occ_reg;
                    if (request.req_type == dsq_pkg::REQ_INSERT)
                    begin
                        // insert walks from the tail downwards
                        ptr_next = IDX_W'(occ_reg - CNT_W'(1));
                    end
                    else
                    begin
                        ptr_next = '0;
                    end
                    case (request.req_type)
                        dsq_pkg::REQ_INSERT:
                        begin
                            if (occ_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                status_next = dsq_pkg::ST_FULL;
                                state_next  = S_HEAD;
                            end
                            else if (occ_reg == '0)
                            begin
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_RUN;
                            end
                        end
                        dsq_pkg::REQ_REMOVE_KEY, dsq_pkg::REQ_REMOVE_FIRST:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = dsq_pkg::ST_EMPTY;
                                state_next  = S_HEAD;
                            end
                            else
                            begin
                                state_next = S_RUN;
                            end
                        end
                        default:
                        begin
                            state_next = (occ_reg == '0) ? S_FINISH : S_RUN;
                        end
                    endcase
                end
            end

            S_RUN:
            begin
                // read side
                if (left_reg != '0)
                begin
                    rd_en           = 1'b1;
                    rd_addr         = ptr_reg;
                    left_next       = left_reg - CNT_W'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = ptr_reg;
                    if (op_reg == dsq_pkg::REQ_INSERT)
                    begin
                        ptr_next = ptr_reg - IDX_W'(1);
                    end
                    else
                    begin
                        ptr_next = ptr_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    state_next      = S_FINISH;
                end

                // modify-write side
                if (pend_valid_reg)
                begin
                    case (op_reg)
                        dsq_pkg::REQ_INSERT:
                        begin
                            if (!flag_reg)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = pend_idx_reg + IDX_W'(1);
                                if (rd_data.deadline >= dl_reg)
                                begin
                                    wr_data = rd_data;
                                end
                                else
                                begin
                                    wr_data   = new_entry;
                                    flag_next = 1'b1;
                                end
                            end
                        end
                        dsq_pkg::REQ_REMOVE_KEY, dsq_pkg::REQ_REMOVE_FIRST:
                        begin
                            if (flag_reg)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = pend_idx_reg - IDX_W'(1);
                                wr_data = rd_data;
                            end
                            else if (match)
                            begin
                                flag_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = pend_idx_reg;
                            wr_data = tick_entry;
                            if (rd_data.deadline == 8'd1)
                            begin
                                expired_next = 1'b1;
                            end
                        end
                    endcase
                end
            end

            S_FINISH:
            begin
                case (op_reg)
                    dsq_pkg::REQ_INSERT:
                    begin
                        if (!flag_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            wr_data = new_entry;
                        end
                        occ_next = occ_reg + CNT_W'(1);
                    end
                    dsq_pkg::REQ_REMOVE_KEY, dsq_pkg::REQ_REMOVE_FIRST:
                    begin
                        if (flag_reg)
                        begin
                            occ_next = occ_reg - CNT_W'(1);
                        end
                        else
                        begin
                            status_next = dsq_pkg::ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        occ_next = occ_reg;
                    end
                endcase
                state_next = S_HEAD;
            end

            S_HEAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= dsq_pkg::REQ_INSERT;
            status_reg     <= dsq_pkg::ST_OK;
            occ_reg        <= '0;
            left_reg       <= '0;
            ptr_reg        <= '0;
            pend_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            flag_reg       <= 1'b0;
            expired_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            status_reg     <= status_next;
            occ_reg        <= occ_next;
            left_reg       <= left_next;
            ptr_reg        <= ptr_next;
            pend_idx_reg   <= pend_idx_next;
            pend_valid_reg <= pend_valid_next;
            flag_reg       <= flag_next;
            expired_reg    <= expired_next;
        end
    end

    // Request payload registers
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        dl_reg  <= dl_next;
        pts_reg <= pts_next;
    end

    // Result transfer
    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESULT);

    always_comb
    begin
        result.status     = status_reg;
        result.expired    = expired_reg;
        result.count      = 4'(occ_reg);
        result.head_valid = (occ_reg != '0);
        if (occ_reg != '0)
        begin
            result.head_key      = rd_data.key;
            result.head_deadline = rd_data.deadline;
            result.head_points   = rd_data.points;
        end
        else
        begin
            result.head_key      = 8'd0;
            result.head_deadline = 8'd0;
            result.head_points   = 8'd0;
        end
    end

    // Checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (occ_reg <= CNT_W'(QUEUE_DEPTH)))
        else $error("occupancy above queue depth");

    a_expired_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        expired_reg |=> expired_reg)
        else $error("expired flag cleared");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_occ_only_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FINISH) |=> $stable(occ_reg))
        else $error("occupancy changed outside finish step");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_RUN || state_reg == S_FINISH))
        else $error("store written outside a walk");

endmodule

>>> sim/tb_deadline_sorted_queue.sv
// Self-checking testbench for deadline_sorted_queue: a directed table, then random
// requests, checked against a queue model in the bench or a pinned row's result.
// Depends on dsq_pkg and the deadline_sorted_queue RTL.
`timescale 1ns / 1ps

module tb_deadline_sorted_queue;

    localparam int QDEPTH       = 8;
    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 3 * (QDEPTH + 4);

    // One row of the directed table; pinned rows carry a hand-worked result
    typedef struct {
        dsq_pkg::req_t    req;
        logic [7:0]       key;
        logic [7:0]       dl;
        logic [7:0]       pts;
        bit               pinned;
        dsq_pkg::status_t status;
        logic             expired;
        logic [3:0]       count;
        logic             head_valid;
        logic [7:0]       hkey;
        logic [7:0]       hdl;
        logic [7:0]       hpts;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    dsq_pkg::request_t request;
    logic              done;
    dsq_pkg::result_t  result;

    // Result forced by a pinned directed row, sent alongside the request
    logic              pin_valid;
    dsq_pkg::result_t  pin_result;

    dsq_pkg::entry_t   held_entries[$];
    bit                model_expired;
    dsq_pkg::result_t  pending_results[$];
    int                mismatch_count;
    int                quiet_cycles;

    stim_row_t dir_rows [22] = '{
        '{dsq_pkg::REQ_REMOVE_FIRST, 8'h00, 8'h00, 8'h00,
          1, dsq_pkg::ST_EMPTY,     0, 0, 0, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_REMOVE_KEY,   8'h00, 8'h00, 8'h00,
          1, dsq_pkg::ST_EMPTY,     0, 0, 0, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_TICK,         8'h00, 8'h00, 8'h00,
          1, dsq_pkg::ST_OK,        0, 0, 0, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_INSERT,       8'hFF, 8'hFF, 8'hFF,
          1, dsq_pkg::ST_OK,        0, 1, 1, 8'hFF, 8'hFF, 8'hFF},
        '{dsq_pkg::REQ_INSERT,       8'h00, 8'h00, 8'h00,
          1, dsq_pkg::ST_OK,        0, 2, 1, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_INSERT,       8'hAA, 8'h00, 8'h55,
          1, dsq_pkg::ST_OK,        0, 3, 1, 8'hAA, 8'h00, 8'h55},
        '{dsq_pkg::REQ_REMOVE_KEY,   8'h12, 8'h00, 8'h00,
          1, dsq_pkg::ST_NOT_FOUND, 0, 3, 1, 8'hAA, 8'h00, 8'h55},
        '{dsq_pkg::REQ_TICK,         8'h00, 8'h00, 8'h00,
          1, dsq_pkg::ST_OK,        0, 3, 1, 8'hAA, 8'h00, 8'h55},
        '{dsq_pkg::REQ_INSERT,       8'h01, 8'h01, 8'h01,
          0, dsq_pkg::ST_OK,        0, 0, 0, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_TICK,         8'h00, 8'h00, 8'h00,
          1, dsq_pkg::ST_OK,        1, 4, 1, 8'hAA, 8'h00, 8'h55},
        '{dsq_pkg::REQ_REMOVE_FIRST, 8'h00, 8'h00, 8'h00,
          0, dsq_pkg::ST_OK,        0, 0, 0, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_REMOVE_KEY,   8'h00, 8'h00, 8'h00,
          0, dsq_pkg::ST_OK,        0, 0, 0, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_INSERT,       8'h10, 8'h80, 8'h5A,
          0, dsq_pkg::ST_OK,        0, 0, 0, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_INSERT,       8'h11, 8'h10, 8'hA5,
          0, dsq_pkg::ST_OK,        0, 0, 0, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_INSERT,       8'h12, 8'h7F, 8'h3C,
          0, dsq_pkg::ST_OK,        0, 0, 0, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_INSERT,       8'h13, 8'h01, 8'hC3,
          0, dsq_pkg::ST_OK,        0, 0, 0, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_INSERT,       8'h14, 8'hFE, 8'h0F,
          0, dsq_pkg::ST_OK,        0, 0, 0, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_INSERT,       8'h15, 8'h40, 8'hF0,
          0, dsq_pkg::ST_OK,        0, 0, 0, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_INSERT,       8'h20, 8'h00, 8'hFF,
          1, dsq_pkg::ST_FULL,      1, 8, 1, 8'h01, 8'h00, 8'h01},
        '{dsq_pkg::REQ_REMOVE_KEY,   8'hFF, 8'h00, 8'h00,
          0, dsq_pkg::ST_OK,        0, 0, 0, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_REMOVE_FIRST, 8'h00, 8'h00, 8'h00,
          0, dsq_pkg::ST_OK,        0, 0, 0, 8'h00, 8'h00, 8'h00},
        '{dsq_pkg::REQ_TICK,         8'h00, 8'h00, 8'h00,
          0, dsq_pkg::ST_OK,        0, 0, 0, 8'h00, 8'h00, 8'h00}
    };

    deadline_sorted_queue #(
        .QUEUE_DEPTH (QDEPTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one request to the queue model and return the result it should give
    function automatic dsq_pkg::result_t apply_request(dsq_pkg::request_t rq);
        dsq_pkg::result_t r;
        dsq_pkg::entry_t  e;
        int               pos;
        bit               hit;
        r = '0;
        r.status = dsq_pkg::ST_OK;
        case (rq.req_type)
            dsq_pkg::REQ_INSERT:
            begin
                if (held_entries.size() >= QDEPTH)
                    r.status = dsq_pkg::ST_FULL;
                else
                begin
                    // goes ahead of entries with an equal time
                    pos = 0;
                    while (pos < held_entries.size() &&
                           held_entries[pos].deadline < rq.deadline)
                        pos++;
                    e.key      = rq.key;
                    e.deadline = rq.deadline;
                    e.points   = rq.points;
                    held_entries.insert(pos, e);
                end
            end
            dsq_pkg::REQ_REMOVE_KEY:
            begin
                if (held_entries.size() == 0)
                    r.status = dsq_pkg::ST_EMPTY;
                else
                begin
                    hit = 1'b0;
                    for (int i = 0; i < held_entries.size() && !hit; i++)
                    begin
                        if (held_entries[i].key == rq.key)
                        begin
                            held_entries.delete(i);
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                        r.status = dsq_pkg::ST_NOT_FOUND;
                end
            end
            dsq_pkg::REQ_REMOVE_FIRST:
            begin
                if (held_entries.size() == 0)
                    r.status = dsq_pkg::ST_EMPTY;
                else
                    void'(held_entries.pop_front());
            end
            default:
            begin
                // saturating countdown; only a one-to-zero step flags expiry
                foreach (held_entries[i])
                begin
                    if (held_entries[i].deadline != 8'd0)
                    begin
                        held_entries[i].deadline--;
                        if (held_entries[i].deadline == 8'd0)
                            model_expired = 1'b1;
                    end
                end
            end
        endcase
        r.expired = model_expired;
        r.count   = 4'(held_entries.size());
        if (held_entries.size() != 0)
        begin
            r.head_valid    = 1'b1;
            r.head_key      = held_entries[0].key;
            r.head_deadline = held_entries[0].deadline;
            r.head_points   = held_entries[0].points;
        end
        return r;
    endfunction

    task automatic check_result(dsq_pkg::result_t want, dsq_pkg::result_t got);
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
        end
        if (got.expired !== want.expired)
        begin
            $error("expired: expected %0d, got %0d", want.expired, got.expired);
            mismatch_count++;
        end
        if (got.count !== want.count)
        begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            mismatch_count++;
        end
        if (got.head_valid !== want.head_valid)
        begin
            $error("head_valid: expected %0d, got %0d", want.head_valid, got.head_valid);
            mismatch_count++;
        end
        if (got.head_key !== want.head_key)
        begin
            $error("head_key: expected %0h, got %0h", want.head_key, got.head_key);
            mismatch_count++;
        end
        if (got.head_deadline !== want.head_deadline)
        begin
            $error("head_deadline: expected %0h, got %0h", want.head_deadline,
                   got.head_deadline);
            mismatch_count++;
        end
        if (got.head_points !== want.head_points)
        begin
            $error("head_points: expected %0h, got %0h", want.head_points, got.head_points);
            mismatch_count++;
        end
    endtask

    // Mostly short idle gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the rising edge of the transfer
    task automatic send_request(dsq_pkg::request_t rq, bit pinned, dsq_pkg::result_t res,
                                int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        request    <= rq;
        pin_valid  <= pinned;
        pin_result <= res;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Result checking and prediction at each rising edge
    always @(posedge clk)
    begin
        dsq_pkg::result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_result(want, result);
                end
            end
            if (start && !busy)
            begin
                want = apply_request(request);
                if (pin_valid)
                    want = pin_result;
                pending_results.push_back(want);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        dsq_pkg::request_t rq;
        dsq_pkg::result_t  res;
        stim_row_t         row;
        int                r;
        int                gap;
        bit                no_idle;

        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        pin_valid  = 1'b0;
        pin_result = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            @(negedge clk);
            rq  = '{req_type: row.req, key: row.key, deadline: row.dl, points: row.pts};
            res = '{status: row.status, expired: row.expired, count: row.count,
                    head_valid: row.head_valid, head_key: row.hkey,
                    head_deadline: row.hdl, head_points: row.hpts};
            send_request(rq, row.pinned, res, pick_gap());
        end

        // Random requests; keys drawn mostly from what is held so removals hit
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            @(negedge clk);
            no_idle = ((n / 150) % 3) == 1;
            r = $urandom_range(0, 99);
            if (r < 40)
                rq.req_type = dsq_pkg::REQ_INSERT;
            else if (r < 62)
                rq.req_type = dsq_pkg::REQ_REMOVE_KEY;
            else if (r < 77)
                rq.req_type = dsq_pkg::REQ_REMOVE_FIRST;
            else
                rq.req_type = dsq_pkg::REQ_TICK;

            r = $urandom_range(0, 99);
            if (r < 60 && held_entries.size() != 0)
                rq.key = held_entries[$urandom_range(0, held_entries.size() - 1)].key;
            else if (r < 80)
                rq.key = 8'($urandom_range(0, 7));
            else
                rq.key = 8'($urandom);

            r = $urandom_range(0, 99);
            if (r < 50)
                rq.deadline = 8'($urandom_range(0, 8));
            else if (r < 90)
                rq.deadline = 8'($urandom);
            else
                rq.deadline = (r < 95) ? 8'hFF : 8'h00;

            rq.points = 8'($urandom);
            gap = no_idle ? 0 : pick_gap();
            send_request(rq, 1'b0, '0, gap);
        end

        @(negedge clk);
        start     <= 1'b0;
        pin_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
design/dsq_pkg.sv
design/dsq_ram.sv
design/deadline_sorted_queue.sv
sim/tb_deadline_sorted_queue.sv
